@@ hdl/vzd_pkg.sv @@
package vzd_pkg;

	localparam logic [1:0] MODE_U32 = 2'd0;
	localparam logic [1:0] MODE_U64 = 2'd1;
	localparam logic [1:0] MODE_S32 = 2'd2;
	localparam logic [1:0] MODE_S64 = 2'd3;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
	localparam logic [1:0] STATUS_TRUNC    = 2'd2;

	localparam logic [6:0] POS_LIMIT = 7'd70;
	localparam logic [6:0] POS_STEP  = 7'd7;

	// one classified stream request as it sits in the queue
	typedef struct packed {
		logic       stream_end;
		logic       more;       // continuation bit
		logic [6:0] payload;
		logic       zero_pad;   // payload bits all zero
		logic       is_ff;      // byte == 0xFF
		logic       is_01;      // byte == 0x01
		logic       nib_bad;    // fails the bit-28 nibble check
		logic       high_set;   // any bit above bit 0 set
		logic [1:0] mode;
	} vzd_entry_t;

	function automatic logic is_wide(input logic [1:0] m);
		return (m == MODE_U64) || (m == MODE_S64);
	endfunction

endpackage

@@ hdl/vzd_front.sv @@
module vzd_front import vzd_pkg::*; (
	input  logic [7:0] data_byte,
	input  logic [1:0] mode,
	input  logic       stream_end,
	output vzd_entry_t entry
);

	always_comb begin
		entry.stream_end = stream_end;
		entry.more       = data_byte[7];
		entry.payload    = data_byte[6:0];
		entry.zero_pad   = (data_byte[6:0] == 7'h00);
		entry.is_ff      = (data_byte == 8'hFF);
		entry.is_01      = (data_byte == 8'h01);
		entry.nib_bad    = (data_byte[6:4] != 3'b000) && (data_byte[6:3] != 4'b1111);
		entry.high_set   = (data_byte[7:1] != 7'h00);
		entry.mode       = mode;
	end

endmodule

@@ hdl/vzd_fifo.sv @@
module vzd_fifo import vzd_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  vzd_entry_t push_data,
	output logic       full,
	input  logic       pop,
	output logic       not_empty,
	output vzd_entry_t pop_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	vzd_entry_t        mem_q [DEPTH];
	logic [AW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]     cnt_q;

	assign full      = (cnt_q == CW'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

@@ hdl/vzd_back.sv @@
module vzd_back import vzd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  vzd_entry_t  ent,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] value,
	output logic [1:0]  status
);

	logic [63:0] acc_q;
	logic [6:0]  pos_q;
	logic        inp_q;
	logic [1:0]  mode_q;
	logic        ovf_q;
	logic        out_valid_q;
	logic [63:0] value_q;
	logic [1:0]  status_q;

	logic [63:0] nxt_acc;
	logic [6:0]  nxt_pos;
	logic        nxt_inp;
	logic [1:0]  nxt_mode;
	logic        nxt_ovf;
	logic        emit;
	logic [63:0] e_val;
	logic [1:0]  e_st;
	logic        fire;

	assign fire      = q_valid && (!out_valid_q || out_ready);
	assign q_pop     = fire;
	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign status    = status_q;

	always_comb begin
		logic [63:0] cur_acc;
		logic [6:0]  cur_pos;
		logic        cur_ovf;
		logic [1:0]  cur_mode;
		logic [31:0] acc32;
		logic [31:0] zz32;
		logic [63:0] acc64;
		logic        abort;
		logic        ext_ok;
		logic        ovf_n;

		cur_acc  = inp_q ? acc_q : '0;
		cur_pos  = inp_q ? pos_q : '0;
		cur_ovf  = inp_q ? ovf_q : 1'b0;
		cur_mode = inp_q ? mode_q : ent.mode;
		acc32    = cur_acc[31:0];
		zz32     = '0;
		acc64    = cur_acc;
		abort    = 1'b0;
		ext_ok   = 1'b0;
		ovf_n    = cur_ovf;

		nxt_acc  = acc_q;
		nxt_pos  = pos_q;
		nxt_inp  = inp_q;
		nxt_mode = mode_q;
		nxt_ovf  = ovf_q;
		emit     = 1'b0;
		e_val    = '0;
		e_st     = STATUS_OK;

		if (ent.stream_end) begin
			if (inp_q) begin
				emit = 1'b1;
				e_st = STATUS_TRUNC;
			end
			nxt_acc = '0;
			nxt_pos = '0;
			nxt_inp = 1'b0;
			nxt_ovf = 1'b0;
		end else if (!is_wide(cur_mode)) begin
			if (cur_pos >= 7'd32) begin
				// zero pad fine below position 64; sign extension only if bit 31 is set
				ext_ok = (cur_pos < 7'd63) ? ent.is_ff : ent.is_01;
				abort  = (cur_pos >= 7'd64) || !(ent.zero_pad || (acc32[31] && ext_ok));
			end else if (cur_pos == 7'd28) begin
				abort = ent.nib_bad;
				acc32 = acc32 | {ent.payload[3:0], 28'h0};
			end else begin
				acc32 = acc32 | (32'(ent.payload) << cur_pos[4:0]);
			end
			zz32 = acc32[0] ? ~(acc32 >> 1) : (acc32 >> 1);
			if (abort || !ent.more) begin
				emit = 1'b1;
				if (abort) begin
					e_st = STATUS_OVERFLOW;
				end else if (cur_mode == MODE_S32) begin
					e_val = {{32{zz32[31]}}, zz32};
				end else begin
					e_val = {32'h0, acc32};
				end
				nxt_acc = '0;
				nxt_pos = '0;
				nxt_inp = 1'b0;
				nxt_ovf = 1'b0;
			end else begin
				nxt_acc = {32'h0, acc32};
				nxt_pos = cur_pos + POS_STEP;
				nxt_inp = 1'b1;
				nxt_ovf = 1'b0;
			end
			nxt_mode = cur_mode;
		end else begin
			ovf_n = cur_ovf || ((cur_pos >= 7'd63) && ent.high_set);
			if (cur_pos < 7'd64) begin
				acc64 = cur_acc | (64'(ent.payload) << cur_pos[5:0]);
			end
			nxt_mode = cur_mode;
			if (!ent.more) begin
				emit = 1'b1;
				if (ovf_n) begin
					e_st = STATUS_OVERFLOW;
				end else if (cur_mode == MODE_S64) begin
					e_val = acc64[0] ? ~(acc64 >> 1) : (acc64 >> 1);
				end else begin
					e_val = acc64;
				end
				nxt_acc = '0;
				nxt_pos = '0;
				nxt_inp = 1'b0;
				nxt_ovf = 1'b0;
			end else begin
				nxt_acc = acc64;
				// overlong varints park at the limit
				nxt_pos = (cur_pos > POS_LIMIT - POS_STEP) ? POS_LIMIT : cur_pos + POS_STEP;
				nxt_inp = 1'b1;
				nxt_ovf = ovf_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			pos_q       <= '0;
			inp_q       <= 1'b0;
			mode_q      <= MODE_U32;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				acc_q  <= nxt_acc;
				pos_q  <= nxt_pos;
				inp_q  <= nxt_inp;
				mode_q <= nxt_mode;
				ovf_q  <= nxt_ovf;
			end
			if (fire && emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			value_q  <= e_val;
			status_q <= e_st;
		end
	end

endmodule

@@ hdl/varint_zigzag_decoder_unit.sv @@
// Varint / zigzag decoder: takes one stream byte per request and returns one result per
// finished varint (or per abort, or per end of stream inside a varint). Requests enter a
// QUEUE_DEPTH-entry queue after classification; the decode stage takes one queued request
// per cycle into a single result register, so the sustained rate is one byte per cycle
// while out_ready is high. A varint's last byte is queued; its result is registered on pop,
// without waiting if nothing is queued ahead and the result register is free. Error results carry
// value 0. The mode is sampled on a varint's first byte.
module varint_zigzag_decoder_unit import vzd_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic [1:0]  mode,
	input  logic        stream_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] value,
	output logic [1:0]  status
);

	vzd_entry_t in_ent;
	vzd_entry_t q_ent;
	logic       q_full;
	logic       q_valid;
	logic       q_pop;

	assign in_ready = !q_full;

	vzd_front u_front (
		.data_byte  (data_byte),
		.mode       (mode),
		.stream_end (stream_end),
		.entry      (in_ent)
	);

	vzd_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_valid && !q_full),
		.push_data (in_ent),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.pop_data  (q_ent)
	);

	vzd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.ent       (q_ent),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.value     (value),
		.status    (status)
	);

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != STATUS_OK) |-> value == 64'h0)
		else $error("error result with nonzero value");

	a_full_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> q_valid)
		else $error("queue full but reports empty");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("pop from empty queue");

endmodule
